// File: rtl/lpsc_pkg.sv
// ----------------------------------------------------------------------------
// lpsc_pkg
// Shared types and constants of the laser power and safety controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lpsc_pkg;

    localparam int unsigned PowerW    = 16;
    localparam int unsigned LevelW    = 8;
    localparam int unsigned CountW    = 32;
    localparam int unsigned FireLimW  = 24;
    localparam int unsigned CheckW    = 8;
    localparam int unsigned AlarmW    = 5;
    localparam int unsigned ApbAddrW  = 5;
    localparam int unsigned ApbDataW  = 32;

    localparam logic [CheckW-1:0]   SafetyPeriodTicks = 8'd100;
    localparam logic [PowerW-1:0]   TtlOnDuty         = 16'd6554;
    localparam logic [CountW-1:0]   FireElapsedMax    = '1;

    typedef enum logic [2:0] {
        KIND_TICK    = 3'd0,
        KIND_ENABLE  = 3'd1,
        KIND_DISABLE = 3'd2,
        KIND_FIRE    = 3'd3,
        KIND_STOP    = 3'd4,
        KIND_SETPWR  = 3'd5,
        KIND_ESTOP   = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOT_EN  = 2'd1,
        STAT_REFUSED = 2'd2,
        STAT_ESTOP   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        REG_DRIVE_MODE = 3'd0,
        REG_CHECK_MASK = 3'd1,
        REG_FITTED     = 3'd2,
        REG_DUTY_LIMIT = 3'd3,
        REG_FIRE_LIMIT = 3'd4,
        REG_RAMP_EN    = 3'd5,
        REG_RAMP_STEP  = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_PWM      = 2'd0,
        MODE_TTL      = 2'd1,
        MODE_DAC      = 2'd2,
        MODE_PWM_CONT = 2'd3
    } t_drive_mode;

    typedef struct packed {
        t_drive_mode         drive_mode;
        logic [3:0]          safety_check_mask;
        logic [1:0]          output_fitted;
        logic [PowerW-1:0]   duty_limit;
        logic [FireLimW-1:0] fire_time_limit_ms;
        logic                ramp_enable;
        logic [PowerW-1:0]   ramp_step;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [PowerW-1:0] power_level;
        logic              interlock_level;
        logic              enclosure_level;
        logic              air_assist_level;
        logic              water_flow_level;
    } t_cmd;

    typedef struct packed {
        logic [LevelW-1:0] pwm_duty;
        logic              ttl_out;
        logic [LevelW-1:0] dac_out;
        logic              enable_out;
        logic              firing_out;
        logic [PowerW-1:0] power_now;
        logic [AlarmW-1:0] alarm_flags;
        t_status           command_status;
        logic [CountW-1:0] shots_fired;
        logic [CountW-1:0] fired_time_ms;
    } t_res;

endpackage

`default_nettype wire

// File: rtl/lpsc_if.sv
// ----------------------------------------------------------------------------
// lpsc_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpsc_cmd_if;
    logic            valid;
    logic            ready;
    lpsc_pkg::t_cmd  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lpsc_res_if;
    logic            valid;
    logic            ready;
    lpsc_pkg::t_res  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/lpsc_cfg.sv
// ----------------------------------------------------------------------------
// lpsc_cfg
// APB register file holding the controller configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsc_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lpsc_pkg::ApbAddrW-1:0]   paddr,
    input  wire logic [lpsc_pkg::ApbDataW-1:0]   pwdata,
    output logic      [lpsc_pkg::ApbDataW-1:0]   prdata,
    output logic                                 pready,
    output lpsc_pkg::t_cfg                       o_cfg
);

    lpsc_pkg::t_cfg       r_cfg;
    lpsc_pkg::t_reg_idx   w_idx;
    logic                 w_wr;

    assign w_idx  = lpsc_pkg::t_reg_idx'(paddr[lpsc_pkg::ApbAddrW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_mode         <= lpsc_pkg::MODE_PWM;
            r_cfg.safety_check_mask  <= '0;
            r_cfg.output_fitted      <= '0;
            r_cfg.duty_limit         <= '1;
            r_cfg.fire_time_limit_ms <= 24'd60000;
            r_cfg.ramp_enable        <= 1'b0;
            r_cfg.ramp_step          <= 16'd1311;
        end else if (w_wr) begin
            unique case (w_idx)
                lpsc_pkg::REG_DRIVE_MODE: begin
                    r_cfg.drive_mode <= lpsc_pkg::t_drive_mode'(pwdata[1:0]);
                end
                lpsc_pkg::REG_CHECK_MASK: r_cfg.safety_check_mask  <= pwdata[3:0];
                lpsc_pkg::REG_FITTED:     r_cfg.output_fitted      <= pwdata[1:0];
                lpsc_pkg::REG_DUTY_LIMIT: r_cfg.duty_limit         <= pwdata[15:0];
                lpsc_pkg::REG_FIRE_LIMIT: r_cfg.fire_time_limit_ms <= pwdata[23:0];
                lpsc_pkg::REG_RAMP_EN:    r_cfg.ramp_enable        <= pwdata[0];
                lpsc_pkg::REG_RAMP_STEP:  r_cfg.ramp_step          <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            lpsc_pkg::REG_DRIVE_MODE: prdata = {30'd0, r_cfg.drive_mode};
            lpsc_pkg::REG_CHECK_MASK: prdata = {28'd0, r_cfg.safety_check_mask};
            lpsc_pkg::REG_FITTED:     prdata = {30'd0, r_cfg.output_fitted};
            lpsc_pkg::REG_DUTY_LIMIT: prdata = {16'd0, r_cfg.duty_limit};
            lpsc_pkg::REG_FIRE_LIMIT: prdata = {8'd0, r_cfg.fire_time_limit_ms};
            lpsc_pkg::REG_RAMP_EN:    prdata = {31'd0, r_cfg.ramp_enable};
            lpsc_pkg::REG_RAMP_STEP:  prdata = {16'd0, r_cfg.ramp_step};
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/lpsc_core.sv
// ----------------------------------------------------------------------------
// lpsc_core
// Controller state and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsc_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire lpsc_pkg::t_cmd  i_cmd,
    input  wire lpsc_pkg::t_cfg  i_cfg,
    output lpsc_pkg::t_res       o_res
);

    localparam int unsigned PW = lpsc_pkg::PowerW;
    localparam int unsigned LW = lpsc_pkg::LevelW;
    localparam int unsigned CW = lpsc_pkg::CountW;

    logic                             r_enabled, n_enabled;
    logic                             r_firing,  n_firing;
    logic [PW-1:0]                    r_applied, n_applied;
    logic [PW-1:0]                    r_wanted,  n_wanted;
    logic [CW-1:0]                    r_elapsed, n_elapsed;
    logic [lpsc_pkg::CheckW-1:0]      r_check,   n_check;
    logic [CW-1:0]                    r_total,   n_total;
    logic [CW-1:0]                    r_tally,   n_tally;
    logic [LW-1:0]                    r_pwm,     n_pwm;
    logic                             r_ttl,     n_ttl;
    logic [LW-1:0]                    r_dac,     n_dac;

    logic [3:0]                       w_fail;
    logic                             w_drive;
    logic [lpsc_pkg::AlarmW-1:0]      w_alarms;
    lpsc_pkg::t_status                w_status;
    logic [PW-1:0]                    w_duty;
    logic [LW-1:0]                    w_level;
    logic [CW-1:0]                    w_elapsed_inc;

    // floor(duty / 257): the high byte, less one where it overshoots
    function automatic logic [LW-1:0] level_of(input logic [PW-1:0] duty);
        logic [LW-1:0] hi;
        logic [PW:0]   prod;
        hi   = duty[PW-1:LW];
        prod = {1'b0, hi, hi};
        return (prod > {1'b0, duty}) ? hi - 1'b1 : hi;
    endfunction

    assign w_fail[0] = i_cfg.safety_check_mask[0] &  i_cmd.interlock_level;
    assign w_fail[1] = i_cfg.safety_check_mask[1] &  i_cmd.enclosure_level;
    assign w_fail[2] = i_cfg.safety_check_mask[2] & ~i_cmd.air_assist_level;
    assign w_fail[3] = i_cfg.safety_check_mask[3] & ~i_cmd.water_flow_level;

    assign w_elapsed_inc = (r_elapsed != lpsc_pkg::FireElapsedMax) ? r_elapsed + 1'b1
                                                                   : r_elapsed;

    always_comb begin
        n_enabled = r_enabled;
        n_firing  = r_firing;
        n_applied = r_applied;
        n_wanted  = r_wanted;
        n_elapsed = r_elapsed;
        n_check   = r_check;
        n_total   = r_total;
        n_tally   = r_tally;
        w_drive   = 1'b0;
        w_alarms  = '0;
        w_status  = lpsc_pkg::STAT_OK;

        case (i_cmd.kind)
            lpsc_pkg::KIND_TICK: begin
                if (r_check >= lpsc_pkg::SafetyPeriodTicks) begin
                    n_check     = '0;
                    w_alarms[3:0] = w_fail;
                    if ((w_fail != 4'd0) && r_firing) begin
                        n_firing  = 1'b0;
                        n_enabled = 1'b0;
                        n_applied = '0;
                        n_wanted  = '0;
                        w_drive   = 1'b1;
                        w_status  = lpsc_pkg::STAT_ESTOP;
                    end
                end else begin
                    n_check = r_check + 1'b1;
                end
                if (i_cfg.ramp_enable && n_firing) begin
                    if (r_wanted >= r_applied) begin
                        if (r_wanted - r_applied <= i_cfg.ramp_step) n_applied = r_wanted;
                        else n_applied = r_applied + i_cfg.ramp_step;
                    end else begin
                        if (r_applied - r_wanted <= i_cfg.ramp_step) n_applied = r_wanted;
                        else n_applied = r_applied - i_cfg.ramp_step;
                    end
                    w_drive = 1'b1;
                end
                if (n_firing) begin
                    n_elapsed = w_elapsed_inc;
                    if (w_elapsed_inc > {8'd0, i_cfg.fire_time_limit_ms}) begin
                        w_alarms[4] = 1'b1;
                        n_total     = r_total + w_elapsed_inc;
                        n_firing    = 1'b0;
                        n_elapsed   = '0;
                        n_applied   = '0;
                        w_drive     = 1'b1;
                    end
                end
            end
            lpsc_pkg::KIND_ENABLE: begin
                w_alarms[3:0] = w_fail;
                if (w_fail == 4'd0) n_enabled = 1'b1;
                else w_status = lpsc_pkg::STAT_REFUSED;
            end
            lpsc_pkg::KIND_DISABLE: begin
                n_enabled = 1'b0;
                n_firing  = 1'b0;
                w_drive   = 1'b1;
            end
            lpsc_pkg::KIND_FIRE: begin
                if (!r_enabled) begin
                    w_status = lpsc_pkg::STAT_NOT_EN;
                end else if (w_fail != 4'd0) begin
                    w_alarms[3:0] = w_fail;
                    n_firing  = 1'b0;
                    n_enabled = 1'b0;
                    n_applied = '0;
                    n_wanted  = '0;
                    w_drive   = 1'b1;
                    w_status  = lpsc_pkg::STAT_ESTOP;
                end else begin
                    n_firing  = 1'b1;
                    n_elapsed = '0;
                    n_tally   = r_tally + 1'b1;
                    w_drive   = 1'b1;
                end
            end
            lpsc_pkg::KIND_STOP: begin
                if (r_firing) n_total = r_total + r_elapsed;
                n_firing  = 1'b0;
                n_elapsed = '0;
                n_applied = '0;
                w_drive   = 1'b1;
            end
            lpsc_pkg::KIND_SETPWR: begin
                n_wanted = i_cmd.power_level;
                if (!i_cfg.ramp_enable) begin
                    n_applied = i_cmd.power_level;
                    w_drive   = 1'b1;
                end
            end
            lpsc_pkg::KIND_ESTOP: begin
                n_firing  = 1'b0;
                n_enabled = 1'b0;
                n_applied = '0;
                n_wanted  = '0;
                w_drive   = 1'b1;
                w_status  = lpsc_pkg::STAT_ESTOP;
            end
            default: ;
        endcase
    end

    assign w_duty  = (n_applied < i_cfg.duty_limit) ? n_applied : i_cfg.duty_limit;
    assign w_level = level_of(w_duty);

    always_comb begin
        n_pwm = r_pwm;
        n_ttl = r_ttl;
        n_dac = r_dac;
        if (w_drive) begin
            if (!n_enabled || !n_firing) begin
                n_pwm = '0;
                if (i_cfg.output_fitted[0]) n_ttl = 1'b0;
                if (i_cfg.output_fitted[1]) n_dac = '0;
            end else begin
                case (i_cfg.drive_mode)
                    lpsc_pkg::MODE_TTL: begin
                        if (i_cfg.output_fitted[0]) n_ttl = (w_duty >= lpsc_pkg::TtlOnDuty);
                    end
                    lpsc_pkg::MODE_DAC: begin
                        if (i_cfg.output_fitted[1]) n_dac = w_level;
                    end
                    default: n_pwm = w_level;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_firing  <= 1'b0;
            r_applied <= '0;
            r_wanted  <= '0;
            r_elapsed <= '0;
            r_check   <= '0;
            r_total   <= '0;
            r_tally   <= '0;
            r_pwm     <= '0;
            r_ttl     <= 1'b0;
            r_dac     <= '0;
        end else if (i_adv) begin
            r_enabled <= n_enabled;
            r_firing  <= n_firing;
            r_applied <= n_applied;
            r_wanted  <= n_wanted;
            r_elapsed <= n_elapsed;
            r_check   <= n_check;
            r_total   <= n_total;
            r_tally   <= n_tally;
            r_pwm     <= n_pwm;
            r_ttl     <= n_ttl;
            r_dac     <= n_dac;
        end
    end

    assign o_res.pwm_duty       = n_pwm;
    assign o_res.ttl_out        = n_ttl;
    assign o_res.dac_out        = n_dac;
    assign o_res.enable_out     = n_enabled;
    assign o_res.firing_out     = n_firing;
    assign o_res.power_now      = n_applied;
    assign o_res.alarm_flags    = w_alarms;
    assign o_res.command_status = w_status;
    assign o_res.shots_fired    = n_tally;
    assign o_res.fired_time_ms  = n_total;

endmodule

`default_nettype wire

// File: rtl/laser_power_safety_controller_unit.sv
// ----------------------------------------------------------------------------
// laser_power_safety_controller_unit
// Laser power and safety sequencer with APB configuration.
//
// Command items (tick, enable, disable, fire, stop, set power, emergency
// stop, plus the four safety input levels) enter on i_cmd and each produces
// exactly one result item on o_res, in order.
// An item is taken into an input register, passes through the next-state
// logic as it moves into the result register, and is offered on o_res
// from the result register. One item per cycle is sustained while the
// receiver does not stall; the rate is set by the state update between the
// two registers. When the receiver stalls, the result register holds and
// the input register still takes one more item; i_cmd.ready drops only
// when both are full. Reset clears both registers and returns the
// controller state and the configuration registers to their defaults.
// The user must write configuration through the APB port only while no
// item is in flight; the block does not enforce this. pready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module laser_power_safety_controller_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    lpsc_cmd_if.sink                             i_cmd,
    lpsc_res_if.source                           o_res,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lpsc_pkg::ApbAddrW-1:0]   paddr,
    input  wire logic [lpsc_pkg::ApbDataW-1:0]   pwdata,
    output logic      [lpsc_pkg::ApbDataW-1:0]   prdata,
    output logic                                 pready
);

    logic              r_in_valid;
    lpsc_pkg::t_cmd    r_in;
    logic              r_out_valid;
    lpsc_pkg::t_res    r_out;
    logic              w_adv;
    lpsc_pkg::t_cfg    w_cfg;
    lpsc_pkg::t_res    w_res;

    lpsc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lpsc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cmd   (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || w_adv;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ready) r_in_valid <= i_cmd.valid;
            if (w_adv) r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) r_in <= i_cmd.data;
        if (w_adv) r_out <= w_res;
    end

endmodule

`default_nettype wire
